>>> hw/rtl/xlbp_pkg.sv
// Shared types, constants and helpers for the XCS-LBP 3x3 filter.
`timescale 1ns / 1ps

package xlbp_pkg;

  localparam int LBP_MAX_LINE = 1024;
  localparam int PIX_W        = 8;
  localparam int LW_W         = 11;
  localparam int CODE_W       = 4;
  localparam int SCALED_W     = 8;
  localparam int MIN_WIDTH    = 3;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 neighborhood; nb[0] right, then clockwise to nb[7] above-right
  typedef struct packed {
    pix_t [7:0] nb;
    pix_t       center;
  } lbp_window_t;

  typedef struct packed {
    logic [SCALED_W-1:0] scaled_code;
    logic [CODE_W-1:0]   pattern;
  } lbp_result_t;

  // last column index for a programmed width, with the width clamped to 3..max_line
  function automatic int last_col(logic [LW_W-1:0] lw, int max_line);
    int w;
    w = int'(lw);
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > max_line) w = max_line;
    return w - 1;
  endfunction

  // code * 255 / 16, truncated
  function automatic logic [SCALED_W-1:0] scale_code(logic [CODE_W-1:0] p);
    logic [11:0] t;
    t = {p, 8'b0} - {8'b0, p};
    return t[11:4];
  endfunction

endpackage

>>> hw/rtl/xlbp_code.sv
// XCS-LBP code and scaled code from one 3x3 neighborhood.
`timescale 1ns / 1ps

module xlbp_code (
  input  xlbp_pkg::lbp_window_t win,
  output xlbp_pkg::lbp_result_t res
);
  import xlbp_pkg::*;

  logic [CODE_W-1:0] pattern;

  // bit k: (n_k - n_k+4) + c + (n_k - c)(n_k+4 - c) >= 0
  always_comb begin
    logic signed [8:0]  da, db, dab;
    logic signed [17:0] prod;
    logic signed [18:0] sum;
    pattern = '0;
    for (int k = 0; k < CODE_W; k++) begin
      da   = $signed({1'b0, win.nb[k]}) - $signed({1'b0, win.center});
      db   = $signed({1'b0, win.nb[k+4]}) - $signed({1'b0, win.center});
      dab  = $signed({1'b0, win.nb[k]}) - $signed({1'b0, win.nb[k+4]});
      prod = da * db;
      sum  = 19'(dab) + $signed({11'b0, win.center}) + 19'(prod);
      pattern[k] = ~sum[18];
    end
  end

  assign res.pattern     = pattern;
  assign res.scaled_code = scale_code(pattern);

endmodule

>>> hw/rtl/xcs_lbp_3x3_filter.sv
// Top level of the streaming XCS-LBP 3x3 filter: line memory, window, output queue.
//
//  channel   dir  payload                                      done when
//  s_axis    in   tdata[7:0] pixel, tuser frame_start          tvalid & tready
//  m_axis    out  tdata[7:0] scaled_code, [11:8] pattern,      tvalid & tready
//                 tlast row_end
//  cfg       in   cfg_data line_width                          cfg_we
//
// One pixel per clock sustained while the output queue has room; each item does one read
// and one write-back of the combined line memory.
// Path: the accept edge registers the memory read into stage 1, where the code is formed
// combinationally; the result is then registered in the output queue, which drives m_axis.
// Reset (synchronous) clears positions, pipeline and queue; line memory is not cleared.
// A stalled output only blocks input once the 3-entry queue cannot absorb in-flight items.
`timescale 1ns / 1ps

module xcs_lbp_3x3_filter #(
  parameter int MAX_LINE = xlbp_pkg::LBP_MAX_LINE
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] pixel
  input  logic                      s_axis_tuser,  // frame_start
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // [7:0] scaled_code, [11:8] pattern
  output logic                      m_axis_tlast,  // row_end
  input  logic                      cfg_we,
  input  logic [xlbp_pkg::LW_W-1:0] cfg_data       // line_width
);
  import xlbp_pkg::*;

  localparam int COL_W   = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int MEM_W   = 2 * PIX_W;
  localparam int Q_DEPTH = 3;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [Q_PTR_W-1:0] Q_LAST  = Q_PTR_W'(Q_DEPTH - 1);
  localparam logic [Q_CNT_W-1:0] Q_FULL  = Q_CNT_W'(Q_DEPTH);

  typedef struct packed {
    lbp_result_t res;
    logic        row_end;
  } q_entry_t;

  // position and width
  logic [COL_W-1:0] wlast;
  logic [COL_W-1:0] col, col_cur;
  logic [1:0]       row, row_cur;
  logic             in_fire, is_last, is_emit;

  // stage 1: memory data arrives
  logic             s1_v, s1_emit, s1_last;
  logic [COL_W-1:0] s1_idx;
  pix_t             s1_px;
  logic             fwd_hit;
  logic [MEM_W-1:0] fwd_data;
  logic [MEM_W-1:0] mem_q;
  logic [MEM_W-1:0] mem [MAX_LINE];
  pix_t             top, mid;

  // window: two previous columns of each row
  pix_t top_l2, top_l1, mid_l2, mid_l1, bot_l2, bot_l1;
  lbp_window_t win;
  lbp_result_t res;

  // output queue
  q_entry_t               q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]     q_wr, q_rd;
  logic [Q_CNT_W-1:0]     q_cnt;
  logic                   q_push, q_pop;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign col_cur = s_axis_tuser ? '0 : col;
  assign row_cur = s_axis_tuser ? '0 : row;
  assign is_last = col_cur >= wlast;
  assign is_emit = (row_cur >= 2'd2) && (col_cur >= COL_W'(2));

  // queue room covers the item in stage 1 plus the one taken now
  assign s_axis_tready = (32'(q_cnt) + 32'(s1_v && s1_emit)) < Q_DEPTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      wlast <= COL_W'(last_col(LW_W'(1024), MAX_LINE));
      col   <= '0;
      row   <= '0;
    end else begin
      if (cfg_we) wlast <= COL_W'(last_col(cfg_data, MAX_LINE));
      if (in_fire) begin
        if (is_last) begin
          col <= '0;
          if (row_cur < 2'd2) row <= row_cur + 2'd1;
          else row <= row_cur;
        end else begin
          col <= col_cur + COL_W'(1);
          row <= row_cur;
        end
      end
    end
  end

  // line memory: {upper, middle}; read on accept, write back in stage 1
  always_ff @(posedge clk) begin
    if (in_fire) mem_q <= mem[col_cur];
    if (s1_v) mem[s1_idx] <= {mid, s1_px};
  end

  assign {top, mid} = fwd_hit ? fwd_data : mem_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_fire;
    end
    if (in_fire) begin
      s1_idx  <= col_cur;
      s1_px   <= s_axis_tdata;
      s1_emit <= is_emit;
      s1_last <= is_last;
      // back-to-back hit on the entry being written this cycle (frame restarts)
      fwd_hit  <= s1_v && (s1_idx == col_cur);
      fwd_data <= {mid, s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      top_l2 <= top_l1;
      top_l1 <= top;
      mid_l2 <= mid_l1;
      mid_l1 <= mid;
      bot_l2 <= bot_l1;
      bot_l1 <= s1_px;
    end
  end

  assign win.center = mid_l1;
  assign win.nb[0]  = mid;
  assign win.nb[1]  = s1_px;
  assign win.nb[2]  = bot_l1;
  assign win.nb[3]  = bot_l2;
  assign win.nb[4]  = mid_l2;
  assign win.nb[5]  = top_l2;
  assign win.nb[6]  = top_l1;
  assign win.nb[7]  = top;

  xlbp_code u_code (
    .win (win),
    .res (res)
  );

  assign q_push = s1_v && s1_emit;
  assign q_pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (q_push) q_wr <= (q_wr == Q_LAST) ? '0 : q_wr + Q_PTR_W'(1);
      if (q_pop) q_rd <= (q_rd == Q_LAST) ? '0 : q_rd + Q_PTR_W'(1);
      if (q_push && !q_pop) q_cnt <= q_cnt + Q_CNT_W'(1);
      else if (!q_push && q_pop) q_cnt <= q_cnt - Q_CNT_W'(1);
    end
    if (q_push) q_mem[q_wr] <= '{res: res, row_end: s1_last};
  end

  assign m_axis_tvalid = (q_cnt != '0);
  assign m_axis_tdata  = {4'b0, q_mem[q_rd].res.pattern, q_mem[q_rd].res.scaled_code};
  assign m_axis_tlast  = q_mem[q_rd].row_end;

  a_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_cnt != Q_FULL) || q_pop)
    else $error("output queue overflow");

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= Q_FULL)
    else $error("output queue count out of range");

  a_fwd_valid: assert property (@(posedge clk) disable iff (rst)
    fwd_hit && s1_v |-> $past(in_fire))
    else $error("forwarding flag without a fresh item");

  a_emit_interior: assert property (@(posedge clk) disable iff (rst)
    s1_v && s1_emit |-> s1_idx >= COL_W'(2))
    else $error("result from a border column");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> q_cnt + Q_CNT_W'(s1_v && s1_emit) <= Q_FULL)
    else $error("accepted item without queue room");

endmodule
